### rtl/autokey_cipher_stream_assert.svh
// ----------------------------------------------------------------------------
// Autokey cipher stream assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef AUTOKEY_CIPHER_STREAM_ASSERT_SVH
`define AUTOKEY_CIPHER_STREAM_ASSERT_SVH

// Property must hold at every clock edge outside reset.
`define AKC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define AKC_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error(msg);

`endif

### rtl/akc_pkg.sv
// ----------------------------------------------------------------------------
// Autokey cipher package
// Widths, register indexes, the queued item format and the letter arithmetic.
// ----------------------------------------------------------------------------
package akc_pkg;

  localparam int KEY_MAX   = 16;
  localparam int SLOT_W    = $clog2(KEY_MAX);
  localparam int LEN_W     = SLOT_W + 1;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 2;
  localparam int KEY_W     = 2 * CFG_W;

  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_GAP   = 8'd32;
  localparam logic [8:0] SHIFT_BIAS = 9'd7;
  localparam logic [5:0] ALPHA_LEN  = 6'd26;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DECRYPT_MODE   = 2'd0,
    REG_KEY_LENGTH     = 2'd1,
    REG_KEY_CHARS_LOW  = 2'd2,
    REG_KEY_CHARS_HIGH = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0]        symbol;
    logic [SLOT_W-1:0] slot;
    logic              past_key;
  } op_t;

  function automatic logic [4:0] mod26(input logic [8:0] x);
    logic [8:0] r;
    r = x;
    if (r >= 9'd208) r = r - 9'd208;
    if (r >= 9'd104) r = r - 9'd104;
    if (r >= 9'd52) r = r - 9'd52;
    if (r >= 9'd26) r = r - 9'd26;
    return r[4:0];
  endfunction

  function automatic logic [4:0] key_shift(input logic [7:0] k);
    logic [7:0] lk;
    lk = k;
    if (k >= CH_UPPER_A && k <= CH_UPPER_Z) lk = k + CASE_GAP;
    return mod26({1'b0, lk} + SHIFT_BIAS);
  endfunction

  function automatic logic [7:0] shift_letter(input logic [7:0] c, input logic [4:0] sh,
                                              input logic sub);
    logic [7:0] base;
    logic [7:0] diff;
    logic [5:0] t;
    logic       is_upper;
    logic       is_lower;
    is_upper = (c >= CH_UPPER_A) && (c <= CH_UPPER_Z);
    is_lower = (c >= CH_LOWER_A) && (c <= CH_LOWER_Z);
    base = is_upper ? CH_UPPER_A : CH_LOWER_A;
    diff = c - base;
    if (sub) begin
      t = {1'b0, diff[4:0]} + ALPHA_LEN - {1'b0, sh};
    end else begin
      t = {1'b0, diff[4:0]} + {1'b0, sh};
    end
    if (t >= ALPHA_LEN) t = t - ALPHA_LEN;
    if (!is_upper && !is_lower) return c;
    return base + {3'b000, t[4:0]};
  endfunction

endpackage

### rtl/akc_front.sv
// ----------------------------------------------------------------------------
// Autokey cipher front end
// Tracks the key position within a message and tags each item with its slot.
// ----------------------------------------------------------------------------
`include "autokey_cipher_stream_assert.svh"

module akc_front
  import akc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       symbol_in,
  input  logic             message_start,
  input  logic [LEN_W-1:0] key_length,
  output logic             push_out,
  output op_t              op
);

  logic [SLOT_W-1:0] slot_index;
  logic [SLOT_W-1:0] slot_index_next;
  logic              past_key_phase;
  logic              past_key_phase_next;
  logic [LEN_W-1:0]  len;
  logic [LEN_W-1:0]  cur_slot;
  logic [LEN_W-1:0]  adv_slot;
  logic              cur_phase;

  always_comb begin
    len = key_length;
    if (key_length == '0) len = LEN_W'(1);
    if (key_length > LEN_W'(KEY_MAX)) len = LEN_W'(KEY_MAX);
  end

  always_comb begin
    cur_slot  = message_start ? '0 : {1'b0, slot_index};
    cur_phase = message_start ? 1'b0 : past_key_phase;
    if (cur_slot >= len) cur_slot = '0;
    adv_slot            = cur_slot + LEN_W'(1);
    slot_index_next     = adv_slot[SLOT_W-1:0];
    past_key_phase_next = cur_phase;
    if (adv_slot >= len) begin
      slot_index_next     = '0;
      past_key_phase_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_index     <= '0;
      past_key_phase <= 1'b0;
    end else if (accept) begin
      slot_index     <= slot_index_next;
      past_key_phase <= past_key_phase_next;
    end
  end

  assign push_out    = accept;
  assign op.symbol   = symbol_in;
  assign op.slot     = cur_slot[SLOT_W-1:0];
  assign op.past_key = cur_phase;

  `AKC_ASSERT(front_slot_below_len, push_out |-> ({1'b0, op.slot} < len),
              "front tagged an item with a slot beyond the key length")

endmodule

### rtl/akc_queue.sv
// ----------------------------------------------------------------------------
// Autokey cipher item queue
// Two-entry queue that decouples the front end from the shift stage.
// ----------------------------------------------------------------------------
`include "autokey_cipher_stream_assert.svh"

module akc_queue
  import akc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  wdata,
  output logic full,
  input  logic pop,
  output op_t  rdata,
  output logic empty
);

  op_t        mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      if (do_push && !do_pop) count <= count + 2'd1;
      else if (do_pop && !do_push) count <= count - 2'd1;
    end
  end

  `AKC_NEVER(queue_count_over, count > 2'd2, "item queue count exceeds its depth")
  `AKC_NEVER(queue_pop_empty, pop && empty, "item queue popped while empty")
  `AKC_ASSERT(queue_push_counts, (do_push && !do_pop) |=> (count == $past(count) + 2'd1),
              "item queue lost a pushed item")

endmodule

### rtl/akc_back.sv
// ----------------------------------------------------------------------------
// Autokey cipher shift stage
// Applies the key or history shift, records plaintext and buffers results.
// ----------------------------------------------------------------------------
`include "autokey_cipher_stream_assert.svh"

module akc_back
  import akc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             decrypt_mode,
  input  logic [KEY_W-1:0] key_chars,
  input  logic             op_valid,
  input  op_t              op,
  output logic             op_take,
  input  logic             pop,
  output logic             empty,
  output logic [7:0]       symbol_out
);

  logic [7:0] history [KEY_MAX];
  logic [7:0] obuf [2];
  logic       owr;
  logic       ord;
  logic [1:0] ocount;
  logic [7:0] key_byte;
  logic [7:0] shift_src;
  logic [7:0] result;
  logic [7:0] plain;
  logic       do_pop;

  assign op_take    = op_valid && (ocount != 2'd2);
  assign empty      = (ocount == 2'd0);
  assign do_pop     = pop && !empty;
  assign symbol_out = obuf[ord];

  always_comb begin
    key_byte  = key_chars[{op.slot, 3'b000} +: 8];
    shift_src = op.past_key ? history[op.slot] : key_byte;
    result    = shift_letter(op.symbol, key_shift(shift_src), decrypt_mode);
    plain     = decrypt_mode ? result : op.symbol;
  end

  always_ff @(posedge clk) begin
    if (op_take) begin
      history[op.slot] <= plain;
      obuf[owr]        <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owr    <= 1'b0;
      ord    <= 1'b0;
      ocount <= 2'd0;
    end else begin
      if (op_take) owr <= !owr;
      if (do_pop) ord <= !ord;
      if (op_take && !do_pop) ocount <= ocount + 2'd1;
      else if (do_pop && !op_take) ocount <= ocount - 2'd1;
    end
  end

  `AKC_NEVER(back_count_over, ocount > 2'd2, "result buffer count exceeds its depth")
  `AKC_ASSERT(back_take_shows, (op_take && empty) |=> !empty,
              "a computed item did not reach the result buffer")

endmodule

### rtl/autokey_cipher_stream.sv
// ----------------------------------------------------------------------------
// Autokey cipher stream
// Byte-wide autokey cipher with a queue interface on both sides.
// ----------------------------------------------------------------------------
// An input item (symbol_in, message_start) is accepted at a clock edge with
// push high and full low. Results are read like a queue: while empty is low,
// symbol_out holds the oldest result and pop takes it at the clock edge.
// The configuration registers (decrypt_mode, key_length, key_chars_low,
// key_chars_high) are written through wr_en, wr_index and wr_data; the user
// must write them only while the block is idle, which it does not enforce.
// An accepted item goes into the item queue, then into the result buffer once
// it has room, and can then be popped. One item per cycle is sustained while
// the receiver keeps popping; the history read, shift and write of the shift
// stage together set that rate. When the receiver stops popping, the two-entry
// result buffer and then the two-entry item queue fill and full rises; no item
// is lost. Reset empties both queues, restarts the key position and restores
// the register reset values; the plaintext history is not cleared.
// ----------------------------------------------------------------------------
module autokey_cipher_stream
  import akc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [7:0]           symbol_in,
  input  logic                 message_start,
  output logic                 empty,
  input  logic                 pop,
  output logic [7:0]           symbol_out,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0]     wr_data
);

  logic             decrypt_mode;
  logic [LEN_W-1:0] key_length;
  logic [CFG_W-1:0] key_chars_low;
  logic [CFG_W-1:0] key_chars_high;
  logic             accept;
  logic             front_push;
  op_t              front_op;
  op_t              queue_op;
  logic             queue_empty;
  logic             queue_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      decrypt_mode   <= 1'b0;
      key_length     <= LEN_W'(1);
      key_chars_low  <= '0;
      key_chars_high <= '0;
    end else if (wr_en) begin
      case (cfg_reg_t'(wr_index))
        REG_DECRYPT_MODE:   decrypt_mode   <= wr_data[0];
        REG_KEY_LENGTH:     key_length     <= wr_data[LEN_W-1:0];
        REG_KEY_CHARS_LOW:  key_chars_low  <= wr_data;
        REG_KEY_CHARS_HIGH: key_chars_high <= wr_data;
        default: ;
      endcase
    end
  end

  assign accept = push && !full;

  akc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .symbol_in     (symbol_in),
    .message_start (message_start),
    .key_length    (key_length),
    .push_out      (front_push),
    .op            (front_op)
  );

  akc_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (front_push),
    .wdata (front_op),
    .full  (full),
    .pop   (queue_take),
    .rdata (queue_op),
    .empty (queue_empty)
  );

  akc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .decrypt_mode (decrypt_mode),
    .key_chars    ({key_chars_high, key_chars_low}),
    .op_valid     (!queue_empty),
    .op           (queue_op),
    .op_take      (queue_take),
    .pop          (pop),
    .empty        (empty),
    .symbol_out   (symbol_out)
  );

endmodule

### bench/autokey_cipher_stream_tb.sv
// ----------------------------------------------------------------------------
// Autokey cipher stream testbench
// Drives a directed table and then random messages into the cipher, with
// bursty pushes and a stalling receiver. A predictor of the autokey shift with
// its own copy of the key history and registers gives the expected byte for
// each accepted item not fixed in the table; results are checked in order.
// ----------------------------------------------------------------------------
module autokey_cipher_stream_tb;
  import akc_pkg::*;

  localparam int RANDOM_ITEMS = 1330;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic       is_cfg;
    cfg_reg_t   reg_idx;
    logic [63:0] reg_val;
    logic [7:0] sym;
    logic       start;
    logic       checked;
    logic [7:0] want;
  } stim_row_t;

  logic                 clk;
  logic                 rst;
  logic                 push;
  logic                 full;
  logic [7:0]           symbol_in;
  logic                 message_start;
  logic                 empty;
  logic                 pop;
  logic [7:0]           symbol_out;
  logic                 wr_en;
  cfg_reg_t             wr_index;
  logic [CFG_W-1:0]     wr_data;

  logic                 item_fixed;
  logic [7:0]           fixed_symbol;

  logic                 mode_dec;
  logic [4:0]           key_len;
  logic [63:0]          key_lo;
  logic [63:0]          key_hi;
  logic [7:0]           plain_hist [0:KEY_MAX-1];
  int                   cur_slot;
  logic                 past_key;
  logic                 need_start;

  logic [7:0]           cipher_out_q [$];
  logic [7:0]           predicted;
  logic [7:0]           oldest;
  stim_row_t            stim_tbl [$];
  int                   errors;
  int                   burst_left;
  int                   cycle_count;
  int                   stall_tick;
  int                   stall_mode;
  logic [7:0]           stall_mask;

  autokey_cipher_stream u_dut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .symbol_in     (symbol_in),
    .message_start (message_start),
    .empty         (empty),
    .pop           (pop),
    .symbol_out    (symbol_out),
    .wr_en         (wr_en),
    .wr_index      (wr_index),
    .wr_data       (wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int active_length();
    int len;
    len = key_len;
    if (len == 0) len = 1;
    if (len > KEY_MAX) len = KEY_MAX;
    return len;
  endfunction

  function automatic logic [7:0] cipher_next(input logic [7:0] sym, input logic start);
    int         len;
    int         slot;
    int         shift;
    int         base;
    int         off;
    logic [7:0] kb;
    logic [7:0] lk;
    logic [7:0] res;
    len = active_length();
    if (start) begin
      cur_slot = 0;
      past_key = 1'b0;
    end
    slot = cur_slot;
    if (slot >= len) slot = 0;
    if (past_key) kb = plain_hist[slot];
    else if (slot < 8) kb = key_lo[8*slot +: 8];
    else kb = key_hi[8*(slot-8) +: 8];
    lk = (kb >= CH_UPPER_A && kb <= CH_UPPER_Z) ? kb + CASE_GAP : kb;
    shift = (int'(lk) + 7) % 26;
    if (sym >= CH_UPPER_A && sym <= CH_UPPER_Z) base = CH_UPPER_A;
    else if (sym >= CH_LOWER_A && sym <= CH_LOWER_Z) base = CH_LOWER_A;
    else base = 0;
    res = sym;
    if (base != 0) begin
      off = int'(sym) - base;
      off = mode_dec ? (off + 26 - shift) % 26 : (off + shift) % 26;
      res = 8'(base + off);
    end
    plain_hist[slot] = mode_dec ? res : sym;
    slot++;
    if (slot >= len) begin
      slot = 0;
      past_key = 1'b1;
    end
    cur_slot = slot;
    return res;
  endfunction

  function automatic stim_row_t cfg_row(input cfg_reg_t idx, input logic [63:0] val);
    stim_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic stim_row_t item_row(input logic [7:0] sym, input logic start);
    stim_row_t r;
    r = '0;
    r.sym = sym;
    r.start = start;
    return r;
  endfunction

  function automatic stim_row_t check_row(input logic [7:0] sym, input logic start,
                                          input logic [7:0] want);
    stim_row_t r;
    r = item_row(sym, start);
    r.checked = 1'b1;
    r.want = want;
    return r;
  endfunction

  function automatic logic [7:0] random_letter();
    if ($urandom_range(0, 1) == 0) return CH_UPPER_A + 8'($urandom_range(0, 25));
    return CH_LOWER_A + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [63:0] random_key();
    logic [63:0] k;
    case ($urandom_range(0, 7))
      0: k = '0;
      1: k = '1;
      2: k = {$urandom, $urandom};
      default: begin
        for (int i = 0; i < 8; i++) begin
          k[8*i +: 8] = ($urandom_range(0, 4) == 0) ? 8'($urandom) : random_letter();
        end
      end
    endcase
    return k;
  endfunction

  task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
    int old_len;
    old_len = active_length();
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    case (idx)
      REG_DECRYPT_MODE:   mode_dec = val[0];
      REG_KEY_LENGTH:     key_len = val[4:0];
      REG_KEY_CHARS_LOW:  key_lo = val;
      REG_KEY_CHARS_HIGH: key_hi = val;
      default: ;
    endcase
    // A longer key would read history slots not yet filled in this message.
    if (active_length() > old_len) need_start = 1'b1;
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk);
    while (cipher_out_q.size() != 0) @(posedge clk);
  endtask

  task automatic send_item(input logic [7:0] sym, input logic start, input logic fixed,
                           input logic [7:0] fixed_sym);
    if (burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    push <= 1'b1;
    symbol_in <= sym;
    message_start <= start | need_start;
    item_fixed <= fixed;
    fixed_symbol <= fixed_sym;
    need_start = 1'b0;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) begin
        predicted = cipher_next(symbol_in, message_start);
        cipher_out_q.push_back(item_fixed ? fixed_symbol : predicted);
      end
      if (pop && !empty) begin
        if (cipher_out_q.size() == 0) begin
          $display("%0t: result %h with no item expected", $time, symbol_out);
          errors++;
        end else begin
          oldest = cipher_out_q.pop_front();
          if (symbol_out !== oldest) begin
            $display("%0t: symbol_out expected %h actual %h", $time, oldest, symbol_out);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      stall_tick <= 0;
    end else begin
      stall_tick <= stall_tick + 1;
      if (stall_tick % 64 == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_mask <= 8'($urandom);
      end
      case (stall_mode)
        0: pop <= 1'b1;
        1: pop <= 1'($urandom_range(0, 1));
        2: pop <= ($urandom_range(0, 7) == 0);
        default: pop <= stall_mask[stall_tick % 8];
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int         sent;
    int         msg_left;
    logic       start;
    logic [7:0] sym;
    clk = 1'b0;
    rst = 1'b1;
    push = 1'b0;
    symbol_in = '0;
    message_start = 1'b0;
    pop = 1'b0;
    wr_en = 1'b0;
    wr_index = REG_DECRYPT_MODE;
    wr_data = '0;
    item_fixed = 1'b0;
    fixed_symbol = '0;
    mode_dec = 1'b0;
    key_len = 5'd1;
    key_lo = '0;
    key_hi = '0;
    cur_slot = 0;
    past_key = 1'b0;
    need_start = 1'b0;
    errors = 0;
    burst_left = 0;
    cycle_count = 0;
    stall_tick = 0;
    stall_mode = 0;
    stall_mask = '0;
    sent = 0;
    msg_left = 0;

    // Reset values: one zero key byte, which shifts letters by seven.
    stim_tbl.push_back(check_row(8'h61, 1'b1, 8'h68));
    stim_tbl.push_back(check_row(8'h41, 1'b0, 8'h41));
    stim_tbl.push_back(check_row(8'h00, 1'b0, 8'h00));
    stim_tbl.push_back(check_row(8'hFF, 1'b0, 8'hFF));
    stim_tbl.push_back(item_row(8'h7A, 1'b0));
    stim_tbl.push_back(item_row(8'h5A, 1'b0));
    // Zero key length acts as one; decryption wraps below the first letter.
    stim_tbl.push_back(cfg_row(REG_DECRYPT_MODE, 64'd1));
    stim_tbl.push_back(cfg_row(REG_KEY_LENGTH, 64'd0));
    stim_tbl.push_back(check_row(8'h68, 1'b1, 8'h61));
    stim_tbl.push_back(check_row(8'h62, 1'b0, 8'h62));
    stim_tbl.push_back(check_row(8'h61, 1'b0, 8'h7A));
    // Oversized length saturates; key bytes include non-letters.
    stim_tbl.push_back(cfg_row(REG_DECRYPT_MODE, 64'd0));
    stim_tbl.push_back(cfg_row(REG_KEY_LENGTH, 64'd31));
    stim_tbl.push_back(cfg_row(REG_KEY_CHARS_LOW, 64'h7A615A41405B607B));
    stim_tbl.push_back(cfg_row(REG_KEY_CHARS_HIGH, 64'hFF00807F61616161));
    stim_tbl.push_back(item_row(8'h41, 1'b1));
    stim_tbl.push_back(item_row(8'h7A, 1'b0));
    stim_tbl.push_back(item_row(8'h80, 1'b0));
    // Shrinking the key mid-message puts the slot past the new length.
    stim_tbl.push_back(cfg_row(REG_KEY_LENGTH, 64'd2));
    stim_tbl.push_back(item_row(8'h51, 1'b0));
    stim_tbl.push_back(item_row(8'h77, 1'b0));
    stim_tbl.push_back(item_row(8'h63, 1'b0));
    stim_tbl.push_back(cfg_row(REG_DECRYPT_MODE, 64'd1));
    stim_tbl.push_back(cfg_row(REG_KEY_LENGTH, 64'd3));
    stim_tbl.push_back(item_row(8'h6D, 1'b1));
    stim_tbl.push_back(item_row(8'h4E, 1'b0));
    stim_tbl.push_back(item_row(8'h54, 1'b1));
    stim_tbl.push_back(item_row(8'h35, 1'b0));
    stim_tbl.push_back(item_row(8'h78, 1'b0));
    stim_tbl.push_back(item_row(8'h4B, 1'b0));
    stim_tbl.push_back(item_row(8'h6A, 1'b0));

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < stim_tbl.size(); r++) begin
      if (stim_tbl[r].is_cfg) begin
        if (r == 0 || !stim_tbl[r-1].is_cfg) wait_idle();
        write_reg(stim_tbl[r].reg_idx, stim_tbl[r].reg_val);
        if (r == stim_tbl.size() - 1 || !stim_tbl[r+1].is_cfg) wr_en <= 1'b0;
      end else begin
        send_item(stim_tbl[r].sym, stim_tbl[r].start, stim_tbl[r].checked,
                  stim_tbl[r].want);
      end
    end

    while (sent < RANDOM_ITEMS) begin
      wait_idle();
      if ($urandom_range(0, 1) == 0) write_reg(REG_DECRYPT_MODE, 64'($urandom_range(0, 1)));
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 5))
          0: write_reg(REG_KEY_LENGTH, 64'd0);
          1: write_reg(REG_KEY_LENGTH, 64'd31);
          2: write_reg(REG_KEY_LENGTH, 64'd16);
          3: write_reg(REG_KEY_LENGTH, 64'($urandom_range(17, 30)));
          default: write_reg(REG_KEY_LENGTH, 64'($urandom_range(1, 15)));
        endcase
      end
      if ($urandom_range(0, 2) != 0) write_reg(REG_KEY_CHARS_LOW, random_key());
      if ($urandom_range(0, 2) != 0) write_reg(REG_KEY_CHARS_HIGH, random_key());
      wr_en <= 1'b0;
      repeat ($urandom_range(20, 100)) begin
        if (msg_left == 0) begin
          start = 1'b1;
          msg_left = $urandom_range(1, 40);
        end else begin
          start = ($urandom_range(0, 31) == 0);
        end
        msg_left--;
        case ($urandom_range(0, 9))
          0: sym = 8'($urandom_range(0, 255));
          1: begin
            case ($urandom_range(0, 7))
              0: sym = 8'h00;
              1: sym = 8'hFF;
              2: sym = 8'h40;
              3: sym = 8'h5B;
              4: sym = 8'h60;
              5: sym = 8'h7B;
              6: sym = ($urandom_range(0, 1) == 0) ? CH_UPPER_A : CH_UPPER_Z;
              default: sym = ($urandom_range(0, 1) == 0) ? CH_LOWER_A : CH_LOWER_Z;
            endcase
          end
          default: sym = random_letter();
        endcase
        send_item(sym, start, 1'b0, 8'h00);
        sent++;
      end
    end

    push <= 1'b0;
    @(posedge clk);
    while (cipher_out_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### autokey_cipher_stream.f
+incdir+rtl
rtl/akc_pkg.sv
rtl/akc_front.sv
rtl/akc_queue.sv
rtl/akc_back.sv
rtl/autokey_cipher_stream.sv
bench/autokey_cipher_stream_tb.sv
